@@ design/tbd_pkg.sv @@
// shared types and constants for the temporal block denoiser
// no dependencies; used by the interfaces and imported by all design modules

package tbd_pkg;

   localparam int SAMPLE_W  = 8;
   localparam int COUNT_W   = 3;
   localparam int CSR_IDX_W = 8;
   localparam int CSR_DAT_W = 16;
   localparam int THRESH_W  = 8;
   localparam int BPR_W     = 11;
   localparam int ROWS_W    = 10;
   // wide enough to hold any frame dimension up to the largest parameter value
   localparam int SIZE_W    = 13;

   localparam logic [BPR_W-1:0]  BPR_RESET  = BPR_W'(360);
   localparam logic [ROWS_W-1:0] ROWS_RESET = ROWS_W'(288);
   localparam logic [THRESH_W-1:0] LUMA_TH_RESET   = THRESH_W'(5);
   localparam logic [THRESH_W-1:0] CHROMA_TH_RESET = THRESH_W'(0);

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_LUMA_THRESHOLD   = 8'd0,
      CSR_CHROMA_THRESHOLD = 8'd1,
      CSR_BLOCKS_PER_ROW   = 8'd2,
      CSR_BLOCK_ROWS       = 8'd3
   } csr_idx_type;

   typedef logic [SAMPLE_W-1:0] sample_type;

   // one 4:2:0 block, also the layout of a reference store entry
   typedef struct packed {
      sample_type chroma_v;
      sample_type chroma_u;
      sample_type luma_bottom_right;
      sample_type luma_bottom_left;
      sample_type luma_top_right;
      sample_type luma_top_left;
   } blk_type;

   typedef struct packed {
      logic [THRESH_W-1:0] luma_threshold;
      logic [THRESH_W-1:0] chroma_threshold;
      logic [BPR_W-1:0]    blocks_per_row;
      logic [ROWS_W-1:0]   block_rows;
   } cfg_type;

endpackage

@@ design/tbd_if.sv @@
// valid/ready channel interfaces for the temporal block denoiser
// depends on tbd_pkg for field widths

interface tbd_req_if;
   logic                       valid;
   logic                       ready;
   logic [tbd_pkg::SAMPLE_W-1:0] luma_top_left;
   logic [tbd_pkg::SAMPLE_W-1:0] luma_top_right;
   logic [tbd_pkg::SAMPLE_W-1:0] luma_bottom_left;
   logic [tbd_pkg::SAMPLE_W-1:0] luma_bottom_right;
   logic [tbd_pkg::SAMPLE_W-1:0] chroma_u;
   logic [tbd_pkg::SAMPLE_W-1:0] chroma_v;

   modport source (output valid, luma_top_left, luma_top_right, luma_bottom_left,
                   luma_bottom_right, chroma_u, chroma_v, input ready);
   modport sink (input valid, luma_top_left, luma_top_right, luma_bottom_left,
                 luma_bottom_right, chroma_u, chroma_v, output ready);
endinterface

interface tbd_rsp_if;
   logic                       valid;
   logic                       ready;
   logic [tbd_pkg::SAMPLE_W-1:0] luma_top_left_out;
   logic [tbd_pkg::SAMPLE_W-1:0] luma_top_right_out;
   logic [tbd_pkg::SAMPLE_W-1:0] luma_bottom_left_out;
   logic [tbd_pkg::SAMPLE_W-1:0] luma_bottom_right_out;
   logic [tbd_pkg::SAMPLE_W-1:0] chroma_u_out;
   logic [tbd_pkg::SAMPLE_W-1:0] chroma_v_out;
   logic [tbd_pkg::COUNT_W-1:0]  averaged_count;
   logic                       end_of_frame;

   modport source (output valid, luma_top_left_out, luma_top_right_out,
                   luma_bottom_left_out, luma_bottom_right_out, chroma_u_out,
                   chroma_v_out, averaged_count, end_of_frame, input ready);
   modport sink (input valid, luma_top_left_out, luma_top_right_out,
                 luma_bottom_left_out, luma_bottom_right_out, chroma_u_out,
                 chroma_v_out, averaged_count, end_of_frame, output ready);
endinterface

interface tbd_csr_if;
   logic                          valid;
   logic                          ready;
   logic [tbd_pkg::CSR_IDX_W-1:0] addr;
   logic [tbd_pkg::CSR_DAT_W-1:0] data;

   modport source (output valid, addr, data, input ready);
   modport sink (input valid, addr, data, output ready);
endinterface

@@ design/tbd_csr.sv @@
// configuration registers of the temporal block denoiser
// depends on tbd_pkg and tbd_csr_if

module tbd_csr (
   input  logic             clock,
   input  logic             reset,
   tbd_csr_if.sink          csr_chan,
   output tbd_pkg::cfg_type cfg
);
   import tbd_pkg::*;

   cfg_type cfg_ff;
   cfg_type cfg_in;
   logic    wr_en;

   assign csr_chan.ready = 1'b1;
   assign wr_en          = csr_chan.valid && csr_chan.ready;
   assign cfg            = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         unique case (csr_chan.addr)
            CSR_LUMA_THRESHOLD:   cfg_in.luma_threshold   = csr_chan.data[THRESH_W-1:0];
            CSR_CHROMA_THRESHOLD: cfg_in.chroma_threshold = csr_chan.data[THRESH_W-1:0];
            CSR_BLOCKS_PER_ROW:   cfg_in.blocks_per_row   = csr_chan.data[BPR_W-1:0];
            CSR_BLOCK_ROWS:       cfg_in.block_rows       = csr_chan.data[ROWS_W-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.luma_threshold   <= LUMA_TH_RESET;
         cfg_ff.chroma_threshold <= CHROMA_TH_RESET;
         cfg_ff.blocks_per_row   <= BPR_RESET;
         cfg_ff.block_rows       <= ROWS_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

@@ design/tbd_ref_store.sv @@
// reference frame store: one entry per block, registered read, one write port
// depends on tbd_pkg; bypasses a write that lands on the address read in the same cycle

module tbd_ref_store #(
   parameter int DEPTH  = 524288,
   parameter int ADDR_W = 19
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                rd_en,
   input  logic [ADDR_W-1:0]   rd_addr,
   input  logic                wr_en,
   input  logic [ADDR_W-1:0]   wr_addr,
   input  tbd_pkg::blk_type    wr_data,
   output tbd_pkg::blk_type    rd_data
);
   import tbd_pkg::*;

   blk_type mem [DEPTH];
   blk_type rd_raw_ff;
   blk_type fwd_data_ff;
   logic    fwd_ff;
   logic    fwd_in;

   assign fwd_in  = rd_en && wr_en && (rd_addr == wr_addr);
   assign rd_data = fwd_ff ? fwd_data_ff : rd_raw_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_raw_ff <= mem[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (fwd_in) begin
         fwd_data_ff <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fwd_ff <= 1'b0;
      end else if (rd_en) begin
         fwd_ff <= fwd_in;
      end
   end

endmodule

@@ design/tbd_filter.sv @@
// threshold averaging of one block against its reference block
// depends on tbd_pkg

module tbd_filter (
   input  tbd_pkg::blk_type                 cur,
   input  tbd_pkg::blk_type                 ref_blk,
   input  logic                             first,
   input  logic [tbd_pkg::THRESH_W-1:0]     luma_th,
   input  logic [tbd_pkg::THRESH_W-1:0]     chroma_th,
   output tbd_pkg::blk_type                 res,
   output logic [tbd_pkg::COUNT_W-1:0]      count
);
   import tbd_pkg::*;

   function automatic logic is_near(sample_type a, sample_type b, logic [THRESH_W-1:0] th);
      sample_type d;
      d = (a > b) ? (a - b) : (b - a);
      return d <= th;
   endfunction

   function automatic sample_type rnd_avg(sample_type a, sample_type b);
      logic [SAMPLE_W:0] s;
      s = {1'b0, a} + {1'b0, b} + (SAMPLE_W+1)'(1);
      return s[SAMPLE_W:1];
   endfunction

   logic n_tl, n_tr, n_bl, n_br, n_u, n_v, all_luma;

   always_comb begin
      n_tl = !first && is_near(cur.luma_top_left, ref_blk.luma_top_left, luma_th);
      n_tr = !first && is_near(cur.luma_top_right, ref_blk.luma_top_right, luma_th);
      n_bl = !first && is_near(cur.luma_bottom_left, ref_blk.luma_bottom_left, luma_th);
      n_br = !first && is_near(cur.luma_bottom_right, ref_blk.luma_bottom_right, luma_th);
      all_luma = n_tl && n_tr && n_bl && n_br;
      // chroma only follows when the whole luma block was averaged
      n_u = all_luma && is_near(cur.chroma_u, ref_blk.chroma_u, chroma_th);
      n_v = all_luma && is_near(cur.chroma_v, ref_blk.chroma_v, chroma_th);

      res.luma_top_left = n_tl ? rnd_avg(cur.luma_top_left, ref_blk.luma_top_left)
                               : cur.luma_top_left;
      res.luma_top_right = n_tr ? rnd_avg(cur.luma_top_right, ref_blk.luma_top_right)
                                : cur.luma_top_right;
      res.luma_bottom_left = n_bl ? rnd_avg(cur.luma_bottom_left, ref_blk.luma_bottom_left)
                                  : cur.luma_bottom_left;
      res.luma_bottom_right = n_br ? rnd_avg(cur.luma_bottom_right, ref_blk.luma_bottom_right)
                                   : cur.luma_bottom_right;
      res.chroma_u = n_u ? rnd_avg(cur.chroma_u, ref_blk.chroma_u) : cur.chroma_u;
      res.chroma_v = n_v ? rnd_avg(cur.chroma_v, ref_blk.chroma_v) : cur.chroma_v;

      count = COUNT_W'(n_tl) + COUNT_W'(n_tr) + COUNT_W'(n_bl) + COUNT_W'(n_br);
   end

endmodule

@@ design/temporal_block_denoiser_core.sv @@
// top level of the recursive temporal block denoiser
// depends on tbd_pkg, tbd_if, tbd_csr, tbd_ref_store and tbd_filter

// Takes one 4:2:0 block (four luma, one U, one V) per transaction in raster order and
// returns one filtered block per transaction, one block per clock sustained while rsp
// stays ready. The accepting edge reads the reference entry from the single-port-write
// frame store for the filter stage, which filters against it, and the edge on which
// that stage advances writes the result back as the next frame's reference and loads
// the output register. A result waiting on rsp does not stop new blocks until the
// filter stage is also occupied.
// The store holds MAX_ROW_BLOCKS * MAX_BLOCK_ROWS entries and is not cleared; the whole
// first frame after reset passes through unfiltered and writes its entries. Frame size
// registers of zero act as one and values above the parameters act as the parameters.

module temporal_block_denoiser_core #(
   parameter int MAX_ROW_BLOCKS = 1024,
   parameter int MAX_BLOCK_ROWS = 512
) (
   input  logic     clock,
   input  logic     reset,
   tbd_req_if.sink  req_chan,
   tbd_rsp_if.source rsp_chan,
   tbd_csr_if.sink  csr_chan
);
   import tbd_pkg::*;

   localparam int DEPTH  = MAX_ROW_BLOCKS * MAX_BLOCK_ROWS;
   localparam int ADDR_W = $clog2(DEPTH);
   localparam int COL_W  = $clog2(MAX_ROW_BLOCKS);
   localparam int ROW_W  = $clog2(MAX_BLOCK_ROWS);

   cfg_type cfg;

   // raster position and frame state
   logic [COL_W-1:0] col_ff, col_in;
   logic [ROW_W-1:0] row_ff, row_in;
   logic             first_frame_ff, first_frame_in;

   logic [SIZE_W-1:0] width_eff, height_eff, bpr_ext, rows_ext;
   logic              last_col, last_row, eof;
   logic [ADDR_W-1:0] rd_addr;
   logic              acc;

   // filter stage
   logic              s1_valid_ff;
   blk_type           s1_blk_ff;
   logic              s1_first_ff;
   logic              s1_eof_ff;
   logic [ADDR_W-1:0] s1_addr_ff;
   logic              s1_adv;

   // output register
   logic                out_valid_ff;
   blk_type             out_blk_ff;
   logic [COUNT_W-1:0]  out_count_ff;
   logic                out_eof_ff;

   blk_type            cur_blk, ref_blk, res_blk;
   logic [COUNT_W-1:0] res_count;

   tbd_csr u_csr (
      .clock    (clock),
      .reset    (reset),
      .csr_chan (csr_chan),
      .cfg      (cfg)
   );

   assign s1_adv         = s1_valid_ff && (!out_valid_ff || rsp_chan.ready);
   assign req_chan.ready = !s1_valid_ff || s1_adv;
   assign acc            = req_chan.valid && req_chan.ready;

   always_comb begin
      bpr_ext  = SIZE_W'(cfg.blocks_per_row);
      rows_ext = SIZE_W'(cfg.block_rows);
      if (bpr_ext == '0) begin
         width_eff = SIZE_W'(1);
      end else if (bpr_ext > SIZE_W'(MAX_ROW_BLOCKS)) begin
         width_eff = SIZE_W'(MAX_ROW_BLOCKS);
      end else begin
         width_eff = bpr_ext;
      end
      if (rows_ext == '0) begin
         height_eff = SIZE_W'(1);
      end else if (rows_ext > SIZE_W'(MAX_BLOCK_ROWS)) begin
         height_eff = SIZE_W'(MAX_BLOCK_ROWS);
      end else begin
         height_eff = rows_ext;
      end

      last_col = (SIZE_W'(col_ff) + SIZE_W'(1)) >= width_eff;
      last_row = (SIZE_W'(row_ff) + SIZE_W'(1)) >= height_eff;
      eof      = last_col && last_row;

      col_in         = col_ff;
      row_in         = row_ff;
      first_frame_in = first_frame_ff;
      if (acc) begin
         if (last_col) begin
            col_in = '0;
            if (last_row) begin
               row_in         = '0;
               first_frame_in = 1'b0;
            end else begin
               row_in = row_ff + ROW_W'(1);
            end
         end else begin
            col_in = col_ff + COL_W'(1);
         end
      end

      rd_addr = ADDR_W'(row_ff) * ADDR_W'(MAX_ROW_BLOCKS) + ADDR_W'(col_ff);

      cur_blk.luma_top_left     = req_chan.luma_top_left;
      cur_blk.luma_top_right    = req_chan.luma_top_right;
      cur_blk.luma_bottom_left  = req_chan.luma_bottom_left;
      cur_blk.luma_bottom_right = req_chan.luma_bottom_right;
      cur_blk.chroma_u          = req_chan.chroma_u;
      cur_blk.chroma_v          = req_chan.chroma_v;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff         <= '0;
         row_ff         <= '0;
         first_frame_ff <= 1'b1;
      end else begin
         col_ff         <= col_in;
         row_ff         <= row_in;
         first_frame_ff <= first_frame_in;
      end
   end

   tbd_ref_store #(
      .DEPTH  (DEPTH),
      .ADDR_W (ADDR_W)
   ) u_ref_store (
      .clock   (clock),
      .reset   (reset),
      .rd_en   (acc),
      .rd_addr (rd_addr),
      .wr_en   (s1_adv),
      .wr_addr (s1_addr_ff),
      .wr_data (res_blk),
      .rd_data (ref_blk)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (req_chan.ready) begin
         s1_valid_ff <= req_chan.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (acc) begin
         s1_blk_ff   <= cur_blk;
         s1_first_ff <= first_frame_ff;
         s1_eof_ff   <= eof;
         s1_addr_ff  <= rd_addr;
      end
   end

   tbd_filter u_filter (
      .cur       (s1_blk_ff),
      .ref_blk   (ref_blk),
      .first     (s1_first_ff),
      .luma_th   (cfg.luma_threshold),
      .chroma_th (cfg.chroma_threshold),
      .res       (res_blk),
      .count     (res_count)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (s1_adv) begin
         out_valid_ff <= 1'b1;
      end else if (rsp_chan.ready) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_adv) begin
         out_blk_ff   <= res_blk;
         out_count_ff <= res_count;
         out_eof_ff   <= s1_eof_ff;
      end
   end

   assign rsp_chan.valid                 = out_valid_ff;
   assign rsp_chan.luma_top_left_out     = out_blk_ff.luma_top_left;
   assign rsp_chan.luma_top_right_out    = out_blk_ff.luma_top_right;
   assign rsp_chan.luma_bottom_left_out  = out_blk_ff.luma_bottom_left;
   assign rsp_chan.luma_bottom_right_out = out_blk_ff.luma_bottom_right;
   assign rsp_chan.chroma_u_out          = out_blk_ff.chroma_u;
   assign rsp_chan.chroma_v_out          = out_blk_ff.chroma_v;
   assign rsp_chan.averaged_count        = out_count_ff;
   assign rsp_chan.end_of_frame          = out_eof_ff;

endmodule

@@ dv/tb.sv @@
`timescale 1ns / 100ps
// testbench for temporal_block_denoiser_core: drives random and directed 4:2:0 blocks,
// predicts the recursive threshold filter and checks every returned block.
// depends on tbd_pkg, the channel interfaces in tbd_if and the design files

module tb;
   import tbd_pkg::*;

   localparam int ROW_BLOCKS_MAX = 1024;
   localparam int BLOCK_ROWS_MAX = 512;
   localparam int RANDOM_BLOCKS  = 690;
   localparam int SETTLE_CYCLES  = 6;
   localparam int LONG_HOLD      = 300;
   localparam int HOLD_PHASE     = 3;
   localparam int unsigned RUN_LIMIT_NS = 1_500_000;
   localparam logic [CSR_IDX_W-1:0] CSR_UNUSED = 8'hff;

   typedef struct packed {
      blk_type              samples;
      logic [COUNT_W-1:0]   averaged_count;
      logic                 end_of_frame;
   } filtered_blk_type;

   class denoise_scoreboard;
      logic [THRESH_W-1:0] luma_th;
      logic [THRESH_W-1:0] chroma_th;
      logic [BPR_W-1:0]    bpr;
      logic [ROWS_W-1:0]   rows;
      int unsigned         col;
      int unsigned         row;
      bit                  first_frame;
      blk_type             reference_frame[int unsigned];
      filtered_blk_type    filtered_due[$];
      string               sample_names[6];
      int                  errors;
      int                  checked;
      int                  frames_closed;
      int                  full_blocks;

      function new();
         luma_th = LUMA_TH_RESET;
         chroma_th = CHROMA_TH_RESET;
         bpr = BPR_RESET;
         rows = ROWS_RESET;
         col = 0;
         row = 0;
         first_frame = 1'b1;
         errors = 0;
         checked = 0;
         frames_closed = 0;
         full_blocks = 0;
         sample_names = '{"luma_top_left", "luma_top_right", "luma_bottom_left",
                          "luma_bottom_right", "chroma_u", "chroma_v"};
      endfunction

      function void set_register(logic [CSR_IDX_W-1:0] idx, logic [CSR_DAT_W-1:0] data);
         case (idx)
            CSR_LUMA_THRESHOLD: luma_th = data[THRESH_W-1:0];
            CSR_CHROMA_THRESHOLD: chroma_th = data[THRESH_W-1:0];
            CSR_BLOCKS_PER_ROW: bpr = data[BPR_W-1:0];
            CSR_BLOCK_ROWS: rows = data[ROWS_W-1:0];
            default: ;
         endcase
      endfunction

      function int unsigned cursor_addr();
         return (row % BLOCK_ROWS_MAX) * ROW_BLOCKS_MAX + (col % ROW_BLOCKS_MAX);
      endfunction

      // never-written entries read as zero, the stimulus keeps away from them
      function blk_type reference_at_cursor();
         int unsigned addr;
         addr = cursor_addr();
         return reference_frame.exists(addr) ? reference_frame[addr] : '0;
      endfunction

      function void note_block(blk_type cur);
         filtered_blk_type due;
         blk_type       prior;
         int unsigned   w;
         int unsigned   h;
         int unsigned   addr;
         int            i;
         int            c;
         int            p;
         int            count;
         w = (bpr == 0) ? 1 : ((bpr > ROW_BLOCKS_MAX) ? ROW_BLOCKS_MAX : bpr);
         h = (rows == 0) ? 1 : ((rows > BLOCK_ROWS_MAX) ? BLOCK_ROWS_MAX : rows);
         addr = cursor_addr();
         prior = reference_at_cursor();
         due = '0;
         due.samples = cur;
         count = 0;
         if (!first_frame) begin
            for (i = 0; i < 4; i++) begin
               c = int'(cur[8*i +: 8]);
               p = int'(prior[8*i +: 8]);
               if (((c > p) ? c - p : p - c) <= luma_th) begin
                  due.samples[8*i +: 8] = 8'((c + p + 1) >> 1);
                  count++;
               end
            end
            // chroma follows only when the whole luma block was averaged
            for (i = 4; i < 6; i++) begin
               c = int'(cur[8*i +: 8]);
               p = int'(prior[8*i +: 8]);
               if (count == 4 && ((c > p) ? c - p : p - c) <= chroma_th)
                  due.samples[8*i +: 8] = 8'((c + p + 1) >> 1);
            end
         end
         reference_frame[addr] = due.samples;
         if (col + 1 >= w) begin
            col = 0;
            if (row + 1 >= h) begin
               row = 0;
               due.end_of_frame = 1'b1;
               first_frame = 1'b0;
            end else begin
               row++;
            end
         end else begin
            col++;
         end
         due.averaged_count = COUNT_W'(count);
         filtered_due.push_back(due);
      endfunction

      function void check_result(filtered_blk_type got);
         filtered_blk_type want;
         int            i;
         if (filtered_due.size() == 0) begin
            $display("%0t: result with nothing outstanding, got %h", $time, got);
            errors++;
            return;
         end
         want = filtered_due.pop_front();
         checked++;
         if (want.end_of_frame)
            frames_closed++;
         if (want.averaged_count == 4)
            full_blocks++;
         for (i = 0; i < 6; i++) begin
            if (got.samples[8*i +: 8] !== want.samples[8*i +: 8]) begin
               $display("%0t: %s expected %0d got %0d", $time, sample_names[i],
                        want.samples[8*i +: 8], got.samples[8*i +: 8]);
               errors++;
            end
         end
         if (got.averaged_count !== want.averaged_count) begin
            $display("%0t: averaged_count expected %0d got %0d", $time,
                     want.averaged_count, got.averaged_count);
            errors++;
         end
         if (got.end_of_frame !== want.end_of_frame) begin
            $display("%0t: end_of_frame expected %0b got %0b", $time,
                     want.end_of_frame, got.end_of_frame);
            errors++;
         end
      endfunction
   endclass

   logic clock = 1'b0;
   logic reset;

   tbd_req_if req_chan();
   tbd_rsp_if rsp_chan();
   tbd_csr_if csr_chan();

   denoise_scoreboard sb;
   bit req_steady;
   int holds_requested = 0;
   int holds_served = 0;
   int pause_left = 0;
   int open_left = 0;

   temporal_block_denoiser_core #(
      .MAX_ROW_BLOCKS(ROW_BLOCKS_MAX),
      .MAX_BLOCK_ROWS(BLOCK_ROWS_MAX)
   ) dut (
      .clock(clock),
      .reset(reset),
      .req_chan(req_chan),
      .rsp_chan(rsp_chan),
      .csr_chan(csr_chan)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   function automatic int pick_gap();
      int roll;
      roll = $urandom_range(0, 99);
      if (roll < 55)
         return 0;
      if (roll < 92)
         return $urandom_range(1, 3);
      return $urandom_range(10, 40);
   endfunction

   function automatic logic [THRESH_W-1:0] pick_threshold();
      int roll;
      roll = $urandom_range(0, 9);
      if (roll == 0)
         return '0;
      if (roll == 1)
         return 8'hff;
      if (roll < 7)
         return THRESH_W'($urandom_range(1, 12));
      return THRESH_W'($urandom_range(0, 255));
   endfunction

   // a sample inside or outside the given distance of prior, boundary distance often
   function automatic sample_type sample_near(sample_type prior, int th, bit close_in);
      int p;
      int d;
      int v;
      p = int'(prior);
      if (close_in) begin
         d = ($urandom_range(0, 3) == 0) ? th : $urandom_range(0, th);
         v = $urandom_range(0, 1) ? p + d : p - d;
         if (v > 255)
            v = p - d;
         else if (v < 0)
            v = p + d;
         if (v > 255)
            v = 255;
         if (v < 0)
            v = 0;
      end else begin
         d = th + 1 + (($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, 40));
         if (p + d <= 255 && p >= d)
            v = $urandom_range(0, 1) ? p + d : p - d;
         else if (p + d <= 255)
            v = p + d;
         else if (p >= d)
            v = p - d;
         else
            v = $urandom_range(0, 255);
      end
      return sample_type'(v);
   endfunction

   function automatic blk_type make_block();
      blk_type prior;
      blk_type b;
      int      style;
      int      pick;
      int      i;
      bit      all_in;
      prior = sb.reference_at_cursor();
      style = $urandom_range(0, 99);
      if (style < 10) begin
         for (i = 0; i < 6; i++)
            b[8*i +: 8] = $urandom_range(0, 1) ? 8'hff : 8'h00;
      end else if (style < 25) begin
         b[31:0] = $urandom();
         b[47:32] = 16'($urandom());
      end else begin
         // mostly the whole luma block lands near the reference so chroma gets a say
         all_in = $urandom_range(0, 3) != 0;
         for (i = 0; i < 4; i++)
            b[8*i +: 8] = sample_near(prior[8*i +: 8], int'(sb.luma_th),
                                      all_in || $urandom_range(0, 1));
         for (i = 4; i < 6; i++) begin
            pick = $urandom_range(0, 2);
            if (pick == 0)
               b[8*i +: 8] = prior[8*i +: 8];
            else
               b[8*i +: 8] = sample_near(prior[8*i +: 8], int'(sb.chroma_th), pick == 1);
         end
      end
      return b;
   endfunction

   function automatic blk_type twisted_reference(blk_type flip);
      return sb.reference_at_cursor() ^ flip;
   endfunction

   task automatic send_block(blk_type b);
      int gap;
      gap = req_steady ? 0 : pick_gap();
      @(negedge clock);
      if (gap > 0) begin
         req_chan.valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_chan.valid <= 1'b1;
      req_chan.luma_top_left <= b.luma_top_left;
      req_chan.luma_top_right <= b.luma_top_right;
      req_chan.luma_bottom_left <= b.luma_bottom_left;
      req_chan.luma_bottom_right <= b.luma_bottom_right;
      req_chan.chroma_u <= b.chroma_u;
      req_chan.chroma_v <= b.chroma_v;
      do @(posedge clock); while (!req_chan.ready);
      sb.note_block(b);
   endtask

   task automatic write_register(logic [CSR_IDX_W-1:0] idx, logic [CSR_DAT_W-1:0] data);
      @(negedge clock);
      csr_chan.valid <= 1'b1;
      csr_chan.addr <= idx;
      csr_chan.data <= data;
      do @(posedge clock); while (!csr_chan.ready);
      sb.set_register(idx, data);
      @(negedge clock);
      csr_chan.valid <= 1'b0;
   endtask

   task automatic wait_idle();
      @(negedge clock);
      req_chan.valid <= 1'b0;
      while (sb.filtered_due.size() != 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // sizes stay within the 16 by 8 corner that the first frame filled
   task automatic reconfigure();
      int w;
      int h;
      if ($urandom_range(0, 1))
         write_register(CSR_LUMA_THRESHOLD, {8'($urandom()), pick_threshold()});
      if ($urandom_range(0, 1))
         write_register(CSR_CHROMA_THRESHOLD, {8'($urandom()), pick_threshold()});
      if ($urandom_range(0, 2) == 0) begin
         w = ($urandom_range(0, 3) == 0) ? ($urandom_range(0, 1) ? 0 : 16)
                                         : $urandom_range(1, 16);
         write_register(CSR_BLOCKS_PER_ROW, {5'($urandom()), 11'(w)});
      end
      if ($urandom_range(0, 2) == 0) begin
         h = ($urandom_range(0, 3) == 0) ? ($urandom_range(0, 1) ? 0 : 8)
                                         : $urandom_range(1, 8);
         write_register(CSR_BLOCK_ROWS, {6'($urandom()), 10'(h)});
      end
   endtask

   // output side pacing, with a long hold whenever the stimulus asks for one
   always @(negedge clock) begin
      if (reset) begin
         rsp_chan.ready <= 1'b0;
      end else begin
         if (holds_served != holds_requested) begin
            holds_served++;
            pause_left = LONG_HOLD;
            open_left = 0;
         end else if (pause_left == 0 && open_left == 0) begin
            pause_left = pick_gap();
            open_left = ($urandom_range(0, 9) == 0) ? $urandom_range(40, 150)
                                                    : $urandom_range(1, 8);
         end
         if (pause_left > 0) begin
            pause_left--;
            rsp_chan.ready <= 1'b0;
         end else begin
            open_left--;
            rsp_chan.ready <= 1'b1;
         end
      end
   end

   always @(posedge clock) begin
      filtered_blk_type got;
      if (!reset && rsp_chan.valid && rsp_chan.ready) begin
         got.samples = {rsp_chan.chroma_v_out, rsp_chan.chroma_u_out,
                        rsp_chan.luma_bottom_right_out, rsp_chan.luma_bottom_left_out,
                        rsp_chan.luma_top_right_out, rsp_chan.luma_top_left_out};
         got.averaged_count = rsp_chan.averaged_count;
         got.end_of_frame = rsp_chan.end_of_frame;
         sb.check_result(got);
      end
   end

   initial begin
      #(RUN_LIMIT_NS);
      $display("tb: failure");
      $finish;
   end

   initial begin
      int phase;
      int len;
      int random_sent;
      reset = 1'b1;
      req_chan.valid = 1'b0;
      req_chan.luma_top_left = '0;
      req_chan.luma_top_right = '0;
      req_chan.luma_bottom_left = '0;
      req_chan.luma_bottom_right = '0;
      req_chan.chroma_u = '0;
      req_chan.chroma_v = '0;
      csr_chan.valid = 1'b0;
      csr_chan.addr = '0;
      csr_chan.data = '0;
      rsp_chan.ready = 1'b0;
      sb = new();
      req_steady = 1'b0;
      random_sent = 0;
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // first frame passes through: corner values at the reset frame size
      send_block('0);
      send_block({6{8'hff}});
      send_block({6{8'h55}});
      send_block({6{8'haa}});
      repeat (6) send_block(make_block());

      // oversize settings clamp to the store limits
      wait_idle();
      write_register(CSR_BLOCKS_PER_ROW, 16'hffff);
      write_register(CSR_BLOCK_ROWS, 16'hffff);
      repeat (10) send_block(make_block());

      // shrink mid-row: column 20 wraps, then fill a 16 by 8 corner to close the frame
      wait_idle();
      write_register(CSR_BLOCKS_PER_ROW, 16'd16);
      write_register(CSR_BLOCK_ROWS, 16'd8);
      while (sb.first_frame)
         send_block(make_block());

      // filtering at the reset thresholds
      repeat (40) begin
         send_block(make_block());
         random_sent++;
      end

      // single block frame: unused register index, threshold extremes, chroma gating
      wait_idle();
      write_register(CSR_UNUSED, 16'hffff);
      write_register(CSR_BLOCKS_PER_ROW, 16'h0000);
      write_register(CSR_BLOCK_ROWS, 16'h0000);
      write_register(CSR_LUMA_THRESHOLD, 16'h00ff);
      write_register(CSR_CHROMA_THRESHOLD, 16'h00ff);
      send_block('0);
      send_block({6{8'hff}});
      send_block(twisted_reference('0));
      wait_idle();
      write_register(CSR_LUMA_THRESHOLD, 16'h0000);
      send_block(twisted_reference('0));
      send_block(twisted_reference({8'h80, 8'h80, 8'h00, 8'h00, 8'h00, 8'h01}));
      send_block(twisted_reference({8'h01, 8'h01, 32'h0}));
      wait_idle();
      write_register(CSR_LUMA_THRESHOLD, 16'h00ff);
      write_register(CSR_CHROMA_THRESHOLD, 16'h0000);
      send_block(twisted_reference({8'h00, 8'h01, 32'h0}));
      send_block('0);
      send_block({6{8'hff}});

      phase = 0;
      while (random_sent < RANDOM_BLOCKS) begin
         wait_idle();
         reconfigure();
         req_steady = ($urandom_range(0, 4) == 0) || phase == HOLD_PHASE;
         if (phase == HOLD_PHASE)
            holds_requested++;
         len = (phase == HOLD_PHASE) ? 60 : $urandom_range(8, 80);
         repeat (len) begin
            send_block(make_block());
            random_sent++;
         end
         phase++;
      end

      wait_idle();
      $display("tb: %0d blocks checked, %0d frame ends, %0d with all four luma averaged",
               sb.checked, sb.frames_closed, sb.full_blocks);
      $display("tb: frames from 1x1 to 16x8 after a clamped oversize first frame, %0d phases",
               phase);
      if (sb.errors == 0 && sb.filtered_due.size() == 0)
         $display("tb: success");
      else
         $display("tb: failure");
      $finish;
   end

endmodule
